FILE: rtl/core/spst_pkg.sv
// ----------------------------------------------------------------------------
// spst_pkg
// Shared types and constants of the presence slot table.
// ----------------------------------------------------------------------------
package spst_pkg;

   localparam int SLOTS        = 8;
   localparam int SLOT_W       = 3;
   localparam int ACTIVE_W     = 4;
   localparam int MAX_FOUND    = 16;
   localparam int FOUND_IDX_W  = 4;
   localparam int FOUND_CNT_W  = 5;
   localparam int ADDR_W       = 64;
   localparam int DROP_W       = 8;

   localparam logic [FOUND_CNT_W-1:0] FOUND_FULL = FOUND_CNT_W'(MAX_FOUND);
   localparam logic [DROP_W-1:0]      DROP_MAX   = '1;

   typedef struct packed {
      logic [ADDR_W-1:0] rom_address;
      logic              has_address;
      logic              last_in_round;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot_index;
      logic [ACTIVE_W-1:0] active_count;
      logic [DROP_W-1:0]   dropped_count;
      logic                none_active;
      logic                last_result;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic                   load;
      logic                   rd_en;
      logic [FOUND_IDX_W-1:0] rd_index;
      logic                   mark_found;
      logic                   deactivate;
      logic                   place;
      logic                   emit;
      logic [SLOT_W-1:0]      emit_slot;
      logic                   clear_round;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [FOUND_CNT_W-1:0] found_count;
      logic                   slot_active;
      logic                   slot_last;
      logic                   none_active;
   } dp_status_type;

endpackage

FILE: rtl/core/spst_datapath.sv
// ----------------------------------------------------------------------------
// spst_datapath
// Found-address buffer, slot table, drop counter and result register.
// ----------------------------------------------------------------------------
module spst_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  spst_pkg::req_type      req_item,
   input  spst_pkg::dp_cmd_type   cmd,
   output spst_pkg::dp_status_type status,
   output spst_pkg::rsp_type      rsp_item,
   output logic                   rsp_strobe
);

   logic [spst_pkg::ADDR_W-1:0]      found_mem [spst_pkg::MAX_FOUND];
   logic [spst_pkg::ADDR_W-1:0]      rd_data_ff;

   logic [spst_pkg::ADDR_W-1:0]      slot_addr_ff [spst_pkg::SLOTS];
   logic [spst_pkg::SLOTS-1:0]       flags_ff;
   logic [spst_pkg::SLOTS-1:0]       found_mask_ff;
   logic [spst_pkg::FOUND_CNT_W-1:0] found_count_ff;
   logic [spst_pkg::DROP_W-1:0]      drop_ff;
   spst_pkg::rsp_type                rsp_ff;
   logic                             rsp_strobe_ff;

   logic [spst_pkg::SLOTS-1:0]       match_vec;
   logic [spst_pkg::SLOTS-1:0]       match_first;
   logic [spst_pkg::SLOTS-1:0]       free_first;
   logic [spst_pkg::ACTIVE_W-1:0]    active_cnt;
   logic                             higher_active;
   logic                             buf_full;
   logic                             drop_load;
   logic                             drop_place;
   spst_pkg::rsp_type                rsp_in;
   logic                             rsp_strobe_in;

   always_comb begin
      for (int i = 0; i < spst_pkg::SLOTS; i++) begin
         match_vec[i] = (slot_addr_ff[i] == rd_data_ff);
      end
   end

   // isolate lowest set bit of the match vector and lowest clear bit of the flags
   assign match_first = match_vec & (~match_vec + 1'b1);
   assign free_first  = ~flags_ff & (flags_ff + 1'b1);

   assign buf_full   = (found_count_ff == spst_pkg::FOUND_FULL);
   assign drop_load  = cmd.load && req_item.has_address && buf_full;
   assign drop_place = cmd.place && (match_vec == '0) && (flags_ff == '1);

   always_comb begin
      active_cnt    = '0;
      higher_active = 1'b0;
      for (int i = 0; i < spst_pkg::SLOTS; i++) begin
         active_cnt = active_cnt + spst_pkg::ACTIVE_W'(flags_ff[i]);
         if ((i > int'(cmd.emit_slot)) && flags_ff[i]) begin
            higher_active = 1'b1;
         end
      end
   end

   assign status.found_count = found_count_ff;
   assign status.slot_active = flags_ff[cmd.emit_slot];
   assign status.slot_last   = !higher_active;
   assign status.none_active = (flags_ff == '0);

   always_comb begin
      rsp_in.slot_index    = status.none_active ? '0 : cmd.emit_slot;
      rsp_in.active_count  = active_cnt;
      rsp_in.dropped_count = drop_ff;
      rsp_in.none_active   = status.none_active;
      rsp_in.last_result   = status.none_active || !higher_active;
      rsp_strobe_in        = cmd.emit && (status.none_active || status.slot_active);
   end

   // found buffer: one write port, registered read
   always_ff @(posedge clock) begin
      if (cmd.load && req_item.has_address && !buf_full) begin
         found_mem[found_count_ff[spst_pkg::FOUND_IDX_W-1:0]] <= req_item.rom_address;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= found_mem[cmd.rd_index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < spst_pkg::SLOTS; i++) begin
            slot_addr_ff[i] <= '0;
         end
         flags_ff       <= '0;
         found_mask_ff  <= '0;
         found_count_ff <= '0;
         drop_ff        <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
         if (cmd.load && req_item.has_address && !buf_full) begin
            found_count_ff <= found_count_ff + 1'b1;
         end
         if ((drop_load || drop_place) && (drop_ff != spst_pkg::DROP_MAX)) begin
            drop_ff <= drop_ff + 1'b1;
         end
         if (cmd.mark_found) begin
            found_mask_ff <= found_mask_ff | match_vec;
         end
         if (cmd.deactivate) begin
            flags_ff <= flags_ff & found_mask_ff;
         end
         if (cmd.place) begin
            if (match_vec != '0) begin
               flags_ff <= flags_ff | match_first;
            end else begin
               flags_ff <= flags_ff | free_first;
               for (int i = 0; i < spst_pkg::SLOTS; i++) begin
                  if (free_first[i]) begin
                     slot_addr_ff[i] <= rd_data_ff;
                  end
               end
            end
         end
         if (cmd.clear_round) begin
            found_count_ff <= '0;
            drop_ff        <= '0;
            found_mask_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_strobe_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item   = rsp_ff;
   assign rsp_strobe = rsp_strobe_ff;

endmodule

FILE: rtl/core/spst_ctrl.sv
// ----------------------------------------------------------------------------
// spst_ctrl
// Round sequencer: buffer scan, slot placement and result walk.
// ----------------------------------------------------------------------------
module spst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    last_in_round,
   input  spst_pkg::dp_status_type status,
   output spst_pkg::dp_cmd_type    cmd,
   output logic                    busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_P1_READ,
      ST_P1_CMP,
      ST_P1_APPLY,
      ST_P2_READ,
      ST_P2_PLACE,
      ST_EMIT
   } state_type;

   state_type                        state_ff;
   logic [spst_pkg::FOUND_CNT_W-1:0] k_ff;
   logic [spst_pkg::SLOT_W-1:0]      s_ff;
   logic                             scan_done;
   logic                             emit_done;

   assign scan_done = (k_ff == status.found_count);
   assign emit_done = status.none_active || (status.slot_active && status.slot_last);

   always_comb begin
      cmd.load        = (state_ff == ST_IDLE) && start;
      cmd.rd_en       = ((state_ff == ST_P1_READ) || (state_ff == ST_P2_READ)) && !scan_done;
      cmd.rd_index    = k_ff[spst_pkg::FOUND_IDX_W-1:0];
      cmd.mark_found  = (state_ff == ST_P1_CMP);
      cmd.deactivate  = (state_ff == ST_P1_APPLY);
      cmd.place       = (state_ff == ST_P2_PLACE);
      cmd.emit        = (state_ff == ST_EMIT);
      cmd.emit_slot   = s_ff;
      cmd.clear_round = (state_ff == ST_EMIT) && emit_done;
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         s_ff     <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start && last_in_round) begin
                  state_ff <= ST_P1_READ;
                  k_ff     <= '0;
               end
            end
            ST_P1_READ: begin
               state_ff <= scan_done ? ST_P1_APPLY : ST_P1_CMP;
            end
            ST_P1_CMP: begin
               k_ff     <= k_ff + 1'b1;
               state_ff <= ST_P1_READ;
            end
            ST_P1_APPLY: begin
               k_ff     <= '0;
               state_ff <= ST_P2_READ;
            end
            ST_P2_READ: begin
               if (scan_done) begin
                  s_ff     <= '0;
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_P2_PLACE;
               end
            end
            ST_P2_PLACE: begin
               k_ff     <= k_ff + 1'b1;
               state_ff <= ST_P2_READ;
            end
            ST_EMIT: begin
               s_ff <= s_ff + 1'b1;
               if (emit_done) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: rtl/core/sensor_presence_slot_table.sv
// ----------------------------------------------------------------------------
// sensor_presence_slot_table
// Persistent table of bus device addresses refreshed by discovery rounds.
// ----------------------------------------------------------------------------
// usage
//   input: drive req_item and raise start; a transfer happens at the edge
//   where start is high and busy is low
//   an item that does not close the round is buffered if it has an address
//   and the buffer is not full, else it is dropped; busy stays low, so
//   such items may come back to back
//   an item with last_in_round set closes the round: busy rises while the
//   found buffer (up to 16 addresses) is scanned twice through its single
//   registered read port and then the slots are walked (1 to 8 of them)
//   output: one result per active slot in ascending slot order, each on
//   rsp_item for exactly one cycle with rsp_strobe high; the receiver
//   cannot stall, so every strobed cycle is a completed transfer
//   when no slot is active a single result with none_active set is sent
//   reset clears the slot table, the active flags and the round counters
//   dropped_count covers only the round that just closed
// ----------------------------------------------------------------------------
module sensor_presence_slot_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  spst_pkg::req_type req_item,
   output spst_pkg::rsp_type rsp_item,
   output logic              rsp_strobe
);

   // command and status between sequencer and datapath
   spst_pkg::dp_cmd_type    dp_cmd;
   spst_pkg::dp_status_type dp_status;

   // sequencer: decides the phase of the round
   spst_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .last_in_round (req_item.last_in_round),
      .status        (dp_status),
      .cmd           (dp_cmd),
      .busy          (busy)
   );

   // datapath: buffer, slots, counters and output register
   spst_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (dp_cmd),
      .status     (dp_status),
      .rsp_item   (rsp_item),
      .rsp_strobe (rsp_strobe)
   );

`ifndef SYNTHESIS
   // a transfer that does not close the round leaves the block ready
   a_open_item_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_item.last_in_round) |=> !busy)
      else $error("busy after non-closing transfer");

   // results only come out of a closing round
   a_strobe_in_round: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result outside a round");

   // an empty-table result is final and has a zero count
   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.none_active) |->
         (rsp_item.last_result && (rsp_item.active_count == '0)))
      else $error("empty-table result malformed");

   // nothing follows the final result directly
   a_last_ends_list: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last_result) |=> !rsp_strobe)
      else $error("result after final result");
`endif

endmodule
